// ===== rtl/md5v_pkg.sv =====
// shared types, round constants and index functions for the md5 variant checksum
// no dependencies
package md5v_pkg;

    localparam int unsigned WordW    = 32;
    localparam int unsigned ByteW    = 8;
    localparam int unsigned BlkWords = 16;
    localparam int unsigned Rounds   = 64;
    localparam int unsigned PadLimit = 56;

    localparam logic [WordW-1:0] Iv0 = 32'h67452301;
    localparam logic [WordW-1:0] Iv1 = 32'hefcdab89;
    localparam logic [WordW-1:0] Iv2 = 32'h98badcfe;
    localparam logic [WordW-1:0] Iv3 = 32'h10325476;
    localparam logic [ByteW-1:0] PadByte = 8'h80;

    typedef struct packed {
        logic       init_chain;
        logic       start;
        logic       round_en;
        logic [5:0] round;
        logic       finish;
    } t_core_ctl;

    function automatic logic [WordW-1:0] md5v_kconst(input logic [5:0] i);
        logic [WordW-1:0] k;
        case (i)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5v_rot(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // message word index used by round i
    function automatic logic [3:0] md5v_widx(input logic [5:0] i);
        logic [3:0] x;
        logic [3:0] v;
        x = i[3:0];
        case (i[5:4])
            2'd0:    v = x;
            2'd1:    v = 4'((x << 2) + x + 4'd1);
            2'd2:    v = 4'((x << 1) + x + 4'd5);
            default: v = 4'((x << 3) - x);
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/md5v_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module md5v_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/md5v_core.sv =====
// md5 compression datapath: chain words, working registers, one round per cycle while round_en is set
// depends on md5v_pkg
module md5v_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  md5v_pkg::t_core_ctl   i_ctl,
    input  logic [31:0]           i_word,
    output logic [127:0]          o_chain
);
    import md5v_pkg::*;

    logic [WordW-1:0] r_chain [4];
    logic [WordW-1:0] r_a, r_b, r_c, r_d;
    logic [WordW-1:0] f, sum, rotv;
    logic [2*WordW-1:0] dbl;

    always_comb begin
        case (i_ctl.round[5:4])
            2'd0:    f = r_d ^ (r_b & (r_c ^ r_d));
            2'd1:    f = r_c ^ (r_d & (r_b ^ r_c));
            2'd2:    f = r_b ^ r_c ^ r_d;
            default: f = r_c ^ (r_b | ~r_d);
        endcase
        sum  = r_a + f + i_word + md5v_kconst(i_ctl.round);
        dbl  = {sum, sum} << md5v_rot(i_ctl.round);
        rotv = dbl[2*WordW-1:WordW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain[0] <= Iv0;
            r_chain[1] <= Iv1;
            r_chain[2] <= Iv2;
            r_chain[3] <= Iv3;
        end else if (i_ctl.init_chain) begin
            r_chain[0] <= Iv0;
            r_chain[1] <= Iv1;
            r_chain[2] <= Iv2;
            r_chain[3] <= Iv3;
        end else if (i_ctl.finish) begin
            r_chain[0] <= r_chain[0] + r_a;
            r_chain[1] <= r_chain[1] + r_b;
            r_chain[2] <= r_chain[2] + r_c;
            r_chain[3] <= r_chain[3] + r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
        end else if (i_ctl.round_en) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= r_b + rotv;
        end
    end

    assign o_chain = {r_chain[3], r_chain[2], r_chain[1], r_chain[0]};

endmodule

// ===== rtl/md5_variant_block_checksum.sv =====
// Byte-serial checksum built on the md5 compression with a modified final padding.
// One transaction per cycle is taken while a block is filling. The transaction that
// completes a 64-byte block keeps the input stalled while the working words load as
// the first round word is read from the 16 x 32 block ram, while the 64 rounds run
// and while the chain is updated. A transaction that carries last compresses one
// padding block, or two when its tail holds 56 or more bytes, after the full block it
// may complete, and then keeps the input stalled while the digest moves to the output
// register, and for as long as the previous digest still waits there. The next
// message can start while the new digest waits.
// Depends on md5v_pkg, md5v_ram and md5v_core.
module md5_variant_block_checksum (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_digest_low,
    output logic [63:0] o_digest_high
);
    import md5v_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN, S_DONE} t_state;
    typedef enum logic [1:0] {K_FULL, K_PAD1, K_PADA, K_PADB} t_kind;
    typedef enum logic [2:0] {W_RAM, W_PART, W_BITLEN, W_ODD, W_ZERO} t_wsel;

    t_state       r_state, n_state;
    t_kind        r_kind, n_kind;
    t_wsel        r_wsel, wsel;
    logic [5:0]   r_pos, n_pos;
    logic [31:0]  r_len;
    logic [31:0]  r_acc;
    logic [6:0]   r_cnt;
    logic         r_last_pend;
    logic         r_rvalid;
    logic [5:0]   r_rrnd;
    logic         r_out_valid;
    logic [63:0]  r_dig_lo, r_dig_hi;

    logic         in_acc, slot_free;
    logic [3:0]   j, fw, ram_raddr;
    logic [31:0]  ram_rdata, part, word;
    logic         ram_we;
    logic [127:0] chain;
    t_core_ctl    ctl;

    assign in_acc    = i_in_valid && o_in_ready;
    assign slot_free = !r_out_valid || i_out_ready;
    assign n_pos     = i_byte_valid ? 6'(r_pos + 6'd1) : r_pos;
    assign ram_we    = in_acc && i_byte_valid && (r_pos[1:0] == 2'd3);

    md5v_ram #(
        .WIDTH(WordW),
        .DEPTH(BlkWords)
    ) u_blk_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos[5:2]),
        .i_wdata ({i_data_byte, r_acc[23:0]}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // word selection for the round issued this cycle
    always_comb begin
        j         = md5v_widx(r_cnt[5:0]);
        fw        = r_pos[5:2];
        ram_raddr = j;
        wsel      = W_ZERO;
        case (r_kind)
            K_FULL: wsel = W_RAM;
            K_PAD1: begin
                ram_raddr = 4'(j - 4'd1);
                if (j == 4'd0) begin
                    wsel = W_BITLEN;
                end else if (j == 4'd15) begin
                    wsel = W_ODD;
                end else if (4'(j - 4'd1) < fw) begin
                    wsel = W_RAM;
                end else if (4'(j - 4'd1) == fw) begin
                    wsel = W_PART;
                end
            end
            K_PADA: begin
                if (j < fw) begin
                    wsel = W_RAM;
                end else if (j == fw) begin
                    wsel = W_PART;
                end
            end
            K_PADB: begin
                if (j == 4'd0) begin
                    wsel = W_BITLEN;
                end else if (j == 4'd15) begin
                    wsel = W_ODD;
                end
            end
            default: wsel = W_ZERO;
        endcase
    end

    // tail word: held bytes, then the pad byte, then zeros
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            if (l < int'(r_pos[1:0])) begin
                part[8*l +: 8] = r_acc[8*l +: 8];
            end else if (l == int'(r_pos[1:0])) begin
                part[8*l +: 8] = PadByte;
            end else begin
                part[8*l +: 8] = 8'h00;
            end
        end
    end

    always_comb begin
        case (r_wsel)
            W_RAM:    word = ram_rdata;
            W_PART:   word = part;
            W_BITLEN: word = {r_len[28:0], 3'b000};
            W_ODD:    word = {r_len[30:0], 1'b1};
            default:  word = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_byte_valid && (r_pos == 6'd63)) begin
                        n_state = S_RUN;
                        n_kind  = K_FULL;
                    end else if (i_last) begin
                        n_state = S_RUN;
                        n_kind  = (n_pos < 6'(PadLimit)) ? K_PAD1 : K_PADA;
                    end
                end
            end
            S_RUN: begin
                if (r_cnt == 7'(Rounds)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                case (r_kind)
                    K_FULL: begin
                        n_state = r_last_pend ? S_RUN : S_IDLE;
                        n_kind  = K_PAD1;
                    end
                    K_PADA: begin
                        n_state = S_RUN;
                        n_kind  = K_PADB;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_DONE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= K_FULL;
            r_pos       <= '0;
            r_len       <= '0;
            r_cnt       <= '0;
            r_last_pend <= 1'b0;
            r_rvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_rvalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (in_acc) begin
                        r_last_pend <= i_last;
                        r_pos       <= n_pos;
                        if (i_byte_valid) begin
                            r_len <= r_len + 32'd1;
                        end
                    end
                end
                S_RUN: begin
                    if (r_cnt != 7'(Rounds)) begin
                        r_rvalid <= 1'b1;
                    end
                    r_cnt <= r_cnt + 7'd1;
                end
                S_FIN: begin
                    r_cnt <= '0;
                end
                S_DONE: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_pos       <= '0;
                        r_len       <= '0;
                        r_last_pend <= 1'b0;
                    end
                end
                default: r_cnt <= '0;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc && i_byte_valid) begin
            r_acc[8*r_pos[1:0] +: 8] <= i_data_byte;
        end
        r_wsel <= wsel;
        r_rrnd <= r_cnt[5:0];
        if (r_state == S_DONE && slot_free) begin
            r_dig_lo <= chain[63:0];
            r_dig_hi <= chain[127:64];
        end
    end

    always_comb begin
        ctl.init_chain = (r_state == S_DONE) && slot_free;
        ctl.start      = (r_state == S_RUN) && (r_cnt == 7'd0);
        ctl.round_en   = r_rvalid;
        ctl.round      = r_rrnd;
        ctl.finish     = (r_state == S_FIN);
    end

    md5v_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_word  (word),
        .o_chain (chain)
    );

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_digest_low  = r_dig_lo;
    assign o_digest_high = r_dig_hi;

endmodule

// ===== rtl/md5v_chk.sv =====
// port-level checker for md5_variant_block_checksum, with its bind
// depends on md5_variant_block_checksum only through its ports
module md5v_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_last,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [63:0] o_digest_low,
    input logic [63:0] o_digest_high
);

    // held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transaction");

    // held result keeps its digest
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_digest_low) && $stable(o_digest_high))
        else $error("digest changed while stalled");

    // end of message makes the block busy with padding
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_last |=> !o_in_ready)
        else $error("input taken during padding");

    // a digest never appears right after the final transaction
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_last |=> ##1 !$rose(o_out_valid))
        else $error("digest before compression finished");

endmodule

bind md5_variant_block_checksum md5v_chk u_md5v_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_last        (i_last),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_digest_low  (o_digest_low),
    .o_digest_high (o_digest_high)
);

// ===== tb/md5_variant_block_checksum_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for md5_variant_block_checksum: byte stream in, digest out
// uses its own compression and padding predictor; depends on md5v_pkg and the rtl
module md5_variant_block_checksum_test;
    import md5v_pkg::*;

    localparam int RandItems   = 1100;
    localparam int CalmFrom    = 1000;
    localparam int StallLimit  = 1000;
    localparam int SettleWait  = 200;
    localparam int ErrShown    = 10;
    localparam int DirRows     = 17;

    // shift amounts, four per stage, index 0 at the right
    localparam logic [15:0][4:0] ROT_TAB = {
        5'd21, 5'd15, 5'd10, 5'd6,  5'd23, 5'd16, 5'd11, 5'd4,
        5'd20, 5'd14, 5'd9,  5'd5,  5'd22, 5'd17, 5'd12, 5'd7
    };

    typedef struct packed {
        logic [7:0] data;
        logic       bv;
        logic       lst;
    } t_stim;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } t_digest;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_byte_valid;
    logic        i_last;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [63:0] o_digest_low;
    logic [63:0] o_digest_high;

    md5_variant_block_checksum u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_byte_valid (i_byte_valid),
        .i_last       (i_last),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_digest_low (o_digest_low),
        .o_digest_high(o_digest_high)
    );

    // predictor state
    logic [31:0]  add_k [64];
    logic [31:0]  chain_acc [4];
    logic [511:0] blk_buf;
    logic [31:0]  msg_len;
    logic [5:0]   fill_pos;

    t_digest digest_q [$];
    int      mismatch_cnt;
    int      digests_seen;
    int      item_cnt;
    int      blocks_done;
    int      longest_msg;
    int      idle_cycles;
    bit      calm;
    bit      send_gaps;
    bit      stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // additive constants: floor(|sin(k+1)| * 2^32)
    initial begin
        real    sv;
        longint kl;
        for (int k = 0; k < 64; k++) begin
            sv = $sin(k + 1);
            if (sv < 0.0) sv = -sv;
            kl = longint'($floor(sv * 4294967296.0));
            add_k[k] = kl[31:0];
        end
    end

    function automatic void md5v_load_iv();
        chain_acc[0] = Iv0;
        chain_acc[1] = Iv1;
        chain_acc[2] = Iv2;
        chain_acc[3] = Iv3;
        msg_len  = '0;
        fill_pos = '0;
    endfunction

    function automatic void md5v_compress(input logic [511:0] blk);
        logic [31:0] a, b, c, d, f, tmp, sum;
        int g;
        int sh;
        a = chain_acc[0];
        b = chain_acc[1];
        c = chain_acc[2];
        d = chain_acc[3];
        for (int r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin f = d ^ (b & (c ^ d)); g = r; end
                1: begin f = c ^ (d & (b ^ c)); g = (5 * r + 1) % 16; end
                2: begin f = b ^ c ^ d; g = (3 * r + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7 * r) % 16; end
            endcase
            sh  = ROT_TAB[(r / 16) * 4 + r % 4];
            sum = a + f + blk[32*g +: 32] + add_k[r];
            tmp = d;
            d   = c;
            c   = b;
            b   = b + ((sum << sh) | (sum >> (32 - sh)));
            a   = tmp;
        end
        chain_acc[0] += a;
        chain_acc[1] += b;
        chain_acc[2] += c;
        chain_acc[3] += d;
        blocks_done++;
    endfunction

    // variant padding: bit length in front and odd length at the end, or both in a block of their own
    function automatic void md5v_close();
        logic [511:0] pad;
        logic [31:0]  bit_len;
        logic [31:0]  odd_len;
        int t;
        t       = int'(fill_pos);
        bit_len = msg_len << 3;
        odd_len = (msg_len << 1) | 32'd1;
        pad     = '0;
        if (t < PadLimit) begin
            pad[31:0] = bit_len;
            for (int k = 0; k < t; k++) pad[32 + 8*k +: 8] = blk_buf[8*k +: 8];
            pad[32 + 8*t +: 8] = PadByte;
            pad[511:480] = odd_len;
            md5v_compress(pad);
        end else begin
            for (int k = 0; k < t; k++) pad[8*k +: 8] = blk_buf[8*k +: 8];
            pad[8*t +: 8] = PadByte;
            md5v_compress(pad);
            pad = '0;
            pad[31:0] = bit_len;
            pad[511:480] = odd_len;
            md5v_compress(pad);
        end
    endfunction

    function automatic logic md5v_take(input logic [7:0] d, input logic bv, input logic lst,
                                       output t_digest dg);
        dg = '0;
        if (bv) begin
            blk_buf[8*fill_pos +: 8] = d;
            fill_pos = fill_pos + 6'd1;
            msg_len  = msg_len + 32'd1;
            if (fill_pos == 6'd0) md5v_compress(blk_buf);
        end
        if (!lst) return 1'b0;
        if (int'(msg_len) > longest_msg) longest_msg = int'(msg_len);
        md5v_close();
        dg.lo = {chain_acc[1], chain_acc[0]};
        dg.hi = {chain_acc[3], chain_acc[2]};
        md5v_load_iv();
        return 1'b1;
    endfunction

    function automatic t_stim dir_row(input int k);
        case (k)
            0:  return {8'h00, 1'b0, 1'b0};   // idle
            1:  return {8'h00, 1'b0, 1'b1};   // empty message
            2:  return {8'hff, 1'b0, 1'b0};   // idle with junk data
            3:  return {8'h00, 1'b1, 1'b1};
            4:  return {8'hff, 1'b1, 1'b1};
            5:  return {8'h61, 1'b1, 1'b0};
            6:  return {8'h62, 1'b1, 1'b0};
            7:  return {8'h00, 1'b0, 1'b0};   // idle inside a message
            8:  return {8'h63, 1'b1, 1'b1};
            9:  return {8'ha5, 1'b1, 1'b0};
            10: return {8'h5a, 1'b1, 1'b0};
            11: return {8'hc3, 1'b0, 1'b1};   // empty tail, junk data
            12: return {8'h3c, 1'b0, 1'b1};   // empty message right after a digest
            13: return {8'h80, 1'b1, 1'b0};
            14: return {8'h7f, 1'b1, 1'b0};
            15: return {8'h01, 1'b1, 1'b0};
            default: return {8'hfe, 1'b1, 1'b1};
        endcase
    endfunction

    // drive one transaction and account for it at the accepting edge
    task automatic send_item(input logic [7:0] d, input logic bv, input logic lst);
        t_digest dg;
        if (!calm && send_gaps && $urandom_range(0, 2) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= d;
        i_byte_valid <= bv;
        i_last       <= lst;
        do @(posedge i_clk); while (!o_in_ready);
        if (md5v_take(d, bv, lst, dg)) digest_q.push_back(dg);
        item_cnt++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (digest_q.size() != 0) @(posedge i_clk);
    endtask

    // result side: random stall bursts, with stretches of none
    initial begin
        int stall_left;
        int mode_timer;
        stall_left  = 0;
        mode_timer  = 0;
        stall_mode  = 1'b1;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            mode_timer++;
            if (mode_timer == 150) begin
                mode_timer = 0;
                stall_mode = ($urandom_range(0, 2) != 0);
            end
            if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0) i_out_ready <= 1'b1;
            end else if (!calm && stall_mode && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                stall_left = $urandom_range(1, 10);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_digest want;
        bit bad_lo;
        bit bad_hi;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (digest_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= ErrShown)
                    $display("unexpected digest low %h high %h", o_digest_low, o_digest_high);
            end else begin
                want   = digest_q.pop_front();
                bad_lo = (o_digest_low !== want.lo);
                bad_hi = (o_digest_high !== want.hi);
                if (bad_lo || bad_hi) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= ErrShown) begin
                        $display("digest %0d mismatch:", digests_seen);
                        if (bad_lo)
                            $display("  low  expected %h actual %h", want.lo, o_digest_low);
                        if (bad_hi)
                            $display("  high expected %h actual %h", want.hi, o_digest_high);
                    end
                end
                digests_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= StallLimit) begin
            $display("no transaction for %0d cycles", StallLimit);
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_stim row;
        int    len;
        int    msg_cnt;
        bit    sep_tail;
        mismatch_cnt = 0;
        digests_seen = 0;
        item_cnt     = 0;
        blocks_done  = 0;
        longest_msg  = 0;
        idle_cycles  = 0;
        msg_cnt      = 0;
        calm         = 1'b0;
        send_gaps    = 1'b1;
        blk_buf      = '0;
        md5v_load_iv();
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_data_byte  = '0;
        i_byte_valid = 1'b0;
        i_last       = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DirRows; k++) begin
            row = dir_row(k);
            send_item(row.data, row.bv, row.lst);
        end
        wait_drained();
        item_cnt = 0;

        while (item_cnt < RandItems) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: len = $urandom_range(0, 12);
                5, 6, 7:       len = 64 * $urandom_range(0, 1) + $urandom_range(54, 66);
                8:             len = $urandom_range(0, 200);
                default:       len = $urandom_range(118, 130);
            endcase
            send_gaps = 1'($urandom_range(0, 1));
            sep_tail  = (len == 0) || ($urandom_range(0, 3) == 0);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(8'($urandom), 1'b0, 1'b0);
                send_item(8'($urandom), 1'b1, !sep_tail && k == len - 1);
            end
            if (sep_tail) send_item(8'($urandom), 1'b0, 1'b1);
            msg_cnt++;
            if (item_cnt >= CalmFrom) calm = 1'b1;
            if (msg_cnt % 8 == 0) wait_drained();
        end

        i_in_valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (SettleWait) @(posedge i_clk);

        $display("%0d random messages (longest %0d bytes) and %0d directed rows",
                 msg_cnt, longest_msg, DirRows);
        $display("%0d digests checked over %0d compressed blocks, %0d mismatches",
                 digests_seen, blocks_done, mismatch_cnt);
        if (mismatch_cnt == 0 && digest_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
